// ----- sv/onewire_temperature_reader_macros.svh -----
// Assertion macros shared by the one-wire temperature reader RTL.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef ONEWIRE_TEMPERATURE_READER_MACROS_SVH
`define ONEWIRE_TEMPERATURE_READER_MACROS_SVH

// Same-cycle implication, quiet while in reset.
`define OWTR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("owtr same-cycle check failed");

// Next-cycle implication, quiet while in reset.
`define OWTR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("owtr next-cycle check failed");

`endif

// ----- sv/owtr_pkg.sv -----
// Package for the one-wire temperature reader: types, codes and helpers.
// Depends on nothing; used by the interfaces, the sequencer core and the top level.
`default_nettype none

package owtr_pkg;

    localparam int TICK_W     = 10;
    localparam int BYTE_W     = 8;
    localparam int BIT_W      = 3;
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int RAW_W      = 16;
    localparam int HUND_W     = 7;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RESET_LOW,
        PH_RESET_REL,
        PH_WRITE,
        PH_READ
    } phase_t;

    // Steps of the measurement sequence
    localparam logic [STEP_W-1:0] STEP_RESET_A = 4'd0;
    localparam logic [STEP_W-1:0] STEP_SKIP_A  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_CONVERT = 4'd2;
    localparam logic [STEP_W-1:0] STEP_POLL    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_RESET_B = 4'd4;
    localparam logic [STEP_W-1:0] STEP_SKIP_B  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_READ_SP = 4'd6;
    localparam logic [STEP_W-1:0] STEP_READ_LO = 4'd7;
    localparam logic [STEP_W-1:0] STEP_READ_HI = 4'd8;

    // Bus command bytes
    localparam logic [BYTE_W-1:0] OW_SKIP_ROM = 8'hCC;
    localparam logic [BYTE_W-1:0] OW_CONVERT  = 8'h44;
    localparam logic [BYTE_W-1:0] OW_READ_SP  = 8'hBE;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_REL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_SLOT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SLOT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SLOT   = 3'd7;

    typedef struct packed {
        logic [TICK_W-1:0] reset_low;
        logic [TICK_W-1:0] reset_release;
        logic [BYTE_W-1:0] one_low;
        logic [BYTE_W-1:0] one_slot;
        logic [BYTE_W-1:0] zero_low;
        logic [BYTE_W-1:0] zero_slot;
        logic [BYTE_W-1:0] read_sample;
        logic [BYTE_W-1:0] read_slot;
    } cfg_t;

    localparam cfg_t CFG_DEFAULT = '{
        reset_low:     10'd500,
        reset_release: 10'd500,
        one_low:       8'd8,
        one_slot:      8'd70,
        zero_low:      8'd62,
        zero_slot:     8'd64,
        read_sample:   8'd10,
        read_slot:     8'd130
    };

    typedef struct packed {
        phase_t              phase;
        logic [STEP_W-1:0]   step;
        logic [TICK_W-1:0]   slot_tick;
        logic [BIT_W-1:0]    bit_pos;
        logic [BYTE_W-1:0]   shift_byte;
    } seq_t;

    // Per-tick result of the sequencer core, plus whether it sat idle before the tick
    typedef struct packed {
        logic              drive_low;
        logic              busy;
        logic              done;
        logic              was_idle;
        logic [RAW_W-1:0]  raw;
    } tick_res_t;

    // Enter a step: clear slot and bit counters, load the byte to send
    function automatic seq_t begin_step(input logic [STEP_W-1:0] step,
                                        input logic [BYTE_W-1:0] shift_keep);
        seq_t s;
        s.step       = step;
        s.slot_tick  = '0;
        s.bit_pos    = '0;
        s.shift_byte = shift_keep;
        s.phase      = PH_IDLE;
        unique case (step) inside
            STEP_RESET_A, STEP_RESET_B: s.phase = PH_RESET_LOW;
            STEP_SKIP_A, STEP_SKIP_B:
            begin
                s.phase      = PH_WRITE;
                s.shift_byte = OW_SKIP_ROM;
            end
            STEP_CONVERT:
            begin
                s.phase      = PH_WRITE;
                s.shift_byte = OW_CONVERT;
            end
            STEP_READ_SP:
            begin
                s.phase      = PH_WRITE;
                s.shift_byte = OW_READ_SP;
            end
            STEP_POLL, STEP_READ_LO, STEP_READ_HI:
            begin
                s.phase      = PH_READ;
                s.shift_byte = '0;
            end
            default: s.phase = PH_IDLE;
        endcase
        return s;
    endfunction

    // True on the last tick of a span of len ticks (zero acts as one)
    function automatic logic span_ends(input logic [TICK_W-1:0] tick,
                                       input logic [TICK_W-1:0] len);
        return ({1'b0, tick} + (TICK_W+1)'(1)) >= {1'b0, len};
    endfunction

    // floor(nibble * 25 / 4)
    function automatic logic [HUND_W-1:0] hundredths_of(input logic [3:0] nib);
        logic [8:0] prod;
        prod = {5'b0, nib} * 9'd25;
        return prod[8:2];
    endfunction

endpackage

`default_nettype wire

// ----- sv/owtr_if.sv -----
// Handshake interfaces for the tick input and the result output channels.
// Depends on owtr_pkg for field widths.
`default_nettype none

interface owtr_in_if;
    import owtr_pkg::*;
    logic valid;
    logic ready;
    logic cmd;
    logic bus_level;

    modport source (output valid, output cmd, output bus_level, input ready);
    modport sink   (input valid, input cmd, input bus_level, output ready);
endinterface

interface owtr_out_if;
    import owtr_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     drive_low;
    logic                     busy_res;
    logic                     done_res;
    logic [RAW_W-1:0]         raw_reading;
    logic signed [BYTE_W-1:0] whole_degrees;
    logic [HUND_W-1:0]        hundredths;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output raw_reading, output whole_degrees, output hundredths,
                    input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input raw_reading, input whole_degrees, input hundredths,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/onewire_temperature_reader.sv -----
// One-wire temperature reader: each accepted tick gives one registered result.
// Each accepted tick updates the sequencer and loads the result register at the same edge;
// the tick input stays ready while the result register is empty or being drained.
// The sequencer update is combinational: one transaction each clock while the sink keeps up.
// Reset (rst_n low, asynchronous) idles the sequencer, clears the last reading and
// restores the default slot timings; there is no clearing pass.
`default_nettype none
`include "onewire_temperature_reader_macros.svh"

module onewire_temperature_reader (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    owtr_in_if.sink                            tick_in,
    owtr_out_if.source                         res_out,
    input  wire logic                          cfg_we,
    input  wire logic [owtr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [owtr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import owtr_pkg::*;

    // Timing registers; a write takes effect at once, even in the middle of a sequence
    cfg_t               cfg_reg;

    // Result register: one finished transaction waiting for the sink
    logic               out_valid_reg;
    logic               drive_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [RAW_W-1:0]   raw_reg;

    logic               tick_ready_int;
    logic               tick_accept;
    tick_res_t          core_res;

    // Take a tick whenever the result register is free or drains this cycle
    assign tick_ready_int = !out_valid_reg || res_out.ready;
    assign tick_in.ready  = tick_ready_int;
    assign tick_accept    = tick_in.valid && tick_ready_int;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_DEFAULT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RESET_LOW:   cfg_reg.reset_low     <= cfg_data;
                CFG_RESET_REL:   cfg_reg.reset_release <= cfg_data;
                CFG_ONE_LOW:     cfg_reg.one_low       <= cfg_data[BYTE_W-1:0];
                CFG_ONE_SLOT:    cfg_reg.one_slot      <= cfg_data[BYTE_W-1:0];
                CFG_ZERO_LOW:    cfg_reg.zero_low      <= cfg_data[BYTE_W-1:0];
                CFG_ZERO_SLOT:   cfg_reg.zero_slot     <= cfg_data[BYTE_W-1:0];
                CFG_READ_SAMPLE: cfg_reg.read_sample   <= cfg_data[BYTE_W-1:0];
                CFG_READ_SLOT:   cfg_reg.read_slot     <= cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: advances its state only on an accepted tick
    owtr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .advance   (tick_accept),
        .cmd       (tick_in.cmd),
        .bus_level (tick_in.bus_level),
        .res       (core_res)
    );

    // Valid flag: set on an accepted tick, drop once the sink takes the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (tick_accept)
            out_valid_reg <= 1'b1;
        else if (res_out.ready)
            out_valid_reg <= 1'b0;
    end

    // Payload: hold until the next accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg <= 1'b0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            raw_reg   <= '0;
        end
        else if (tick_accept)
        begin
            drive_reg <= core_res.drive_low;
            busy_reg  <= core_res.busy;
            done_reg  <= core_res.done;
            raw_reg   <= core_res.raw;
        end
    end

    assign res_out.valid         = out_valid_reg;
    assign res_out.drive_low     = drive_reg;
    assign res_out.busy_res      = busy_reg;
    assign res_out.done_res      = done_reg;
    assign res_out.raw_reading   = raw_reg;
    assign res_out.whole_degrees = raw_reg[11:4];
    assign res_out.hundredths    = hundredths_of(raw_reg[3:0]);

    // A completion tick always belongs to a running sequence
    `OWTR_ASSERT_NOW(a_done_is_busy, out_valid_reg && done_reg, busy_reg)
    // A start from idle drives the bus low on that very tick
    `OWTR_ASSERT_NEXT(a_start_drives_low, tick_accept && tick_in.cmd && core_res.was_idle,
                      out_valid_reg && busy_reg && drive_reg)
    // The reading only moves when a tick is taken
    `OWTR_ASSERT_NEXT(a_raw_holds, !tick_accept, $stable(raw_reg))

endmodule

`default_nettype wire

// ----- sv/owtr_core.sv -----
// Sequencer core: bus state registers and the one-tick next-state logic.
// Depends on owtr_pkg.
`default_nettype none

module owtr_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  owtr_pkg::cfg_t          cfg,
    input  wire logic               advance,
    input  wire logic               cmd,
    input  wire logic               bus_level,
    output owtr_pkg::tick_res_t     res
);
    import owtr_pkg::*;

    seq_t               seq_reg, seq_next;
    logic [BYTE_W-1:0]  low_byte_reg, low_byte_next;
    logic [RAW_W-1:0]   raw_reg, raw_next;

    always_comb
    begin
        logic              one;
        logic [TICK_W-1:0] low_t;
        logic [TICK_W-1:0] len;
        logic              last;
        logic [TICK_W-1:0] sample;

        seq_next      = seq_reg;
        low_byte_next = low_byte_reg;
        raw_next      = raw_reg;
        res.drive_low = 1'b0;
        res.busy      = 1'b0;
        res.done      = 1'b0;
        res.was_idle  = (seq_reg.phase == PH_IDLE);
        one    = seq_reg.shift_byte[0];
        low_t  = one ? {2'b0, cfg.one_low}  : {2'b0, cfg.zero_low};
        len    = one ? {2'b0, cfg.one_slot} : {2'b0, cfg.zero_slot};
        sample = {2'b0, cfg.read_sample};
        last   = 1'b0;

        // start command while idle: this tick is already the first of the reset pulse
        if (seq_reg.phase == PH_IDLE && cmd)
        begin
            seq_next = begin_step(STEP_RESET_A, seq_reg.shift_byte);
        end

        res.busy = (seq_next.phase != PH_IDLE);

        unique case (seq_next.phase)
            PH_IDLE: ;
            PH_RESET_LOW:
            begin
                res.drive_low = 1'b1;
                if (span_ends(seq_next.slot_tick, cfg.reset_low))
                begin
                    seq_next.phase     = PH_RESET_REL;
                    seq_next.slot_tick = '0;
                end
                else
                begin
                    seq_next.slot_tick = seq_next.slot_tick + TICK_W'(1);
                end
            end
            PH_RESET_REL:
            begin
                if (span_ends(seq_next.slot_tick, cfg.reset_release))
                    seq_next = begin_step(seq_next.step + STEP_W'(1), seq_next.shift_byte);
                else
                    seq_next.slot_tick = seq_next.slot_tick + TICK_W'(1);
            end
            PH_WRITE:
            begin
                res.drive_low = (seq_next.slot_tick < low_t);
                if (span_ends(seq_next.slot_tick, len))
                begin
                    seq_next.slot_tick  = '0;
                    seq_next.shift_byte = {1'b0, seq_next.shift_byte[BYTE_W-1:1]};
                    if (seq_next.bit_pos == 3'd7)
                        seq_next = begin_step(seq_next.step + STEP_W'(1),
                                              seq_next.shift_byte);
                    else
                        seq_next.bit_pos = seq_next.bit_pos + BIT_W'(1);
                end
                else
                begin
                    seq_next.slot_tick = seq_next.slot_tick + TICK_W'(1);
                end
            end
            PH_READ:
            begin
                last          = span_ends(seq_next.slot_tick, {2'b0, cfg.read_slot});
                res.drive_low = (seq_next.slot_tick < TICK_W'(2));
                // sample late if the sample point lies past the slot end
                if (seq_next.slot_tick == sample || (last && sample > seq_next.slot_tick))
                    seq_next.shift_byte = {bus_level, seq_next.shift_byte[BYTE_W-1:1]};
                if (last)
                begin
                    seq_next.slot_tick = '0;
                    if (seq_next.bit_pos == 3'd7)
                    begin
                        if (seq_next.step == STEP_POLL)
                        begin
                            seq_next = begin_step((seq_next.shift_byte != '0) ?
                                                  STEP_RESET_B : STEP_POLL,
                                                  seq_next.shift_byte);
                        end
                        else if (seq_next.step == STEP_READ_LO)
                        begin
                            low_byte_next = seq_next.shift_byte;
                            seq_next = begin_step(STEP_READ_HI, seq_next.shift_byte);
                        end
                        else
                        begin
                            raw_next         = {seq_next.shift_byte, low_byte_next};
                            res.done         = 1'b1;
                            seq_next.phase   = PH_IDLE;
                            seq_next.step    = STEP_RESET_A;
                            seq_next.bit_pos = '0;
                        end
                    end
                    else
                    begin
                        seq_next.bit_pos = seq_next.bit_pos + BIT_W'(1);
                    end
                end
                else
                begin
                    seq_next.slot_tick = seq_next.slot_tick + TICK_W'(1);
                end
            end
            default: ;
        endcase

        res.raw = raw_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg.phase      <= PH_IDLE;
            seq_reg.step       <= STEP_RESET_A;
            seq_reg.slot_tick  <= '0;
            seq_reg.bit_pos    <= '0;
            seq_reg.shift_byte <= '0;
            low_byte_reg       <= '0;
            raw_reg            <= '0;
        end
        else if (advance)
        begin
            seq_reg      <= seq_next;
            low_byte_reg <= low_byte_next;
            raw_reg      <= raw_next;
        end
    end

endmodule

`default_nettype wire

// ----- sim/owtr_reading_checker.sv -----
// Scoreboard for the one-wire temperature reader: predicts each tick's reading and compares it.
// Depends on owtr_pkg; watches the tick, result and register-write ports of the block.

module owtr_reading_checker
    import owtr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     tick_valid,
    input  logic                     tick_ready,
    input  logic                     cmd,
    input  logic                     bus_level,
    input  logic                     res_valid,
    input  logic                     res_ready,
    input  logic                     drive_low,
    input  logic                     busy_res,
    input  logic                     done_res,
    input  logic [RAW_W-1:0]         raw_reading,
    input  logic signed [BYTE_W-1:0] whole_degrees,
    input  logic [HUND_W-1:0]        hundredths,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    output int                       mismatches,
    output int                       pending,
    output int                       readings,
    output logic                     sequence_running
);

    typedef struct packed {
        logic                     drive_low;
        logic                     busy;
        logic                     done;
        logic [RAW_W-1:0]         raw;
        logic signed [BYTE_W-1:0] degrees;
        logic [HUND_W-1:0]        hundredths;
    } reading_t;

    reading_t expected_readings[$];

    // Shadow of the sequencer and its timing registers
    cfg_t              timing;
    phase_t            seq_phase;
    logic [STEP_W-1:0] seq_step;
    logic [TICK_W-1:0] span_tick;
    logic [BIT_W-1:0]  bit_idx;
    logic [BYTE_W-1:0] wire_byte;
    logic [BYTE_W-1:0] low_half;
    logic [RAW_W-1:0]  last_reading;

    function automatic void enter_step(input logic [STEP_W-1:0] s);
        seq_step  = s;
        span_tick = '0;
        bit_idx   = '0;
        case (s)
            STEP_RESET_A, STEP_RESET_B: seq_phase = PH_RESET_LOW;
            STEP_SKIP_A, STEP_SKIP_B:
            begin
                seq_phase = PH_WRITE;
                wire_byte = OW_SKIP_ROM;
            end
            STEP_CONVERT:
            begin
                seq_phase = PH_WRITE;
                wire_byte = OW_CONVERT;
            end
            STEP_READ_SP:
            begin
                seq_phase = PH_WRITE;
                wire_byte = OW_READ_SP;
            end
            STEP_POLL, STEP_READ_LO, STEP_READ_HI:
            begin
                seq_phase = PH_READ;
                wire_byte = '0;
            end
            default: seq_phase = PH_IDLE;
        endcase
    endfunction

    // A span of zero ticks behaves as one tick
    function automatic bit span_done(input int len);
        return int'(span_tick) + 1 >= len;
    endfunction

    function automatic reading_t predict_tick(input logic start, input logic level);
        reading_t   r;
        logic       one;
        logic       fin;
        int         low_len;
        int         slot_len;
        logic [8:0] scaled;
        r = '0;
        if (seq_phase == PH_IDLE && start)
            enter_step(STEP_RESET_A);
        if (seq_phase != PH_IDLE)
        begin
            r.busy = 1'b1;
            case (seq_phase)
                PH_RESET_LOW:
                begin
                    r.drive_low = 1'b1;
                    if (span_done(int'(timing.reset_low)))
                    begin
                        seq_phase = PH_RESET_REL;
                        span_tick = '0;
                    end
                    else
                        span_tick++;
                end
                PH_RESET_REL:
                begin
                    if (span_done(int'(timing.reset_release)))
                        enter_step(seq_step + 1'b1);
                    else
                        span_tick++;
                end
                PH_WRITE:
                begin
                    one      = wire_byte[0];
                    low_len  = one ? int'(timing.one_low) : int'(timing.zero_low);
                    slot_len = one ? int'(timing.one_slot) : int'(timing.zero_slot);
                    r.drive_low = int'(span_tick) < low_len;
                    if (span_done(slot_len))
                    begin
                        span_tick = '0;
                        wire_byte = wire_byte >> 1;
                        if (bit_idx == 3'd7)
                            enter_step(seq_step + 1'b1);
                        else
                            bit_idx++;
                    end
                    else
                        span_tick++;
                end
                PH_READ:
                begin
                    fin = span_done(int'(timing.read_slot));
                    r.drive_low = span_tick < 2;
                    // a sample point beyond the slot falls back to its last tick
                    if (int'(span_tick) == int'(timing.read_sample) ||
                        (fin && int'(timing.read_sample) > int'(span_tick)))
                        wire_byte = {level, wire_byte[BYTE_W-1:1]};
                    if (fin)
                    begin
                        span_tick = '0;
                        if (bit_idx == 3'd7)
                        begin
                            if (seq_step == STEP_POLL)
                                enter_step(wire_byte != '0 ? STEP_RESET_B : STEP_POLL);
                            else if (seq_step == STEP_READ_LO)
                            begin
                                low_half = wire_byte;
                                enter_step(STEP_READ_HI);
                            end
                            else
                            begin
                                last_reading = {wire_byte, low_half};
                                r.done       = 1'b1;
                                seq_phase    = PH_IDLE;
                                seq_step     = STEP_RESET_A;
                                bit_idx      = '0;
                            end
                        end
                        else
                            bit_idx++;
                    end
                    else
                        span_tick++;
                end
                default: ;
            endcase
        end
        scaled       = 9'(last_reading[3:0]) * 9'd25;
        r.raw        = last_reading;
        r.degrees    = last_reading[11:4];
        r.hundredths = scaled[8:2];
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            expected_readings.delete();
            timing           = CFG_DEFAULT;
            seq_phase        = PH_IDLE;
            seq_step         = STEP_RESET_A;
            span_tick        = '0;
            bit_idx          = '0;
            wire_byte        = '0;
            low_half         = '0;
            last_reading     = '0;
            mismatches       = 0;
            readings         <= 0;
            pending          <= 0;
            sequence_running <= 1'b0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    mismatches++;
                    $error("result transaction with no tick awaiting it");
                end
                else
                begin
                    want = expected_readings.pop_front();
                    check_field("drive_low", want.drive_low, drive_low);
                    check_field("busy_res", want.busy, busy_res);
                    check_field("done_res", want.done, done_res);
                    check_field("raw_reading", want.raw, raw_reading);
                    check_field("whole_degrees", want.degrees, whole_degrees);
                    check_field("hundredths", want.hundredths, hundredths);
                end
            end
            // a tick taken at the same edge as a register write still sees the old timing
            if (tick_valid && tick_ready)
            begin
                want = predict_tick(cmd, bus_level);
                if (want.done)
                    readings <= readings + 1;
                expected_readings.push_back(want);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RESET_LOW:   timing.reset_low     = cfg_data;
                    CFG_RESET_REL:   timing.reset_release = cfg_data;
                    CFG_ONE_LOW:     timing.one_low       = cfg_data[BYTE_W-1:0];
                    CFG_ONE_SLOT:    timing.one_slot      = cfg_data[BYTE_W-1:0];
                    CFG_ZERO_LOW:    timing.zero_low      = cfg_data[BYTE_W-1:0];
                    CFG_ZERO_SLOT:   timing.zero_slot     = cfg_data[BYTE_W-1:0];
                    CFG_READ_SAMPLE: timing.read_sample   = cfg_data[BYTE_W-1:0];
                    CFG_READ_SLOT:   timing.read_slot     = cfg_data[BYTE_W-1:0];
                    default: ;
                endcase
            end
            pending          <= expected_readings.size();
            sequence_running <= (seq_phase != PH_IDLE);
        end
    end

endmodule

// ----- sim/tb_top.sv -----
// Top of the one-wire temperature reader testbench: clock, reset, stimulus and verdict.
// Depends on owtr_pkg, the tick and result interfaces, the block and owtr_reading_checker.

module tb_top;
    import owtr_pkg::*;

    // Cycles without any transaction before the run is declared hung. The longest
    // legitimate quiet spell is a long sink stall or sender gap plus the register writes.
    localparam int STALL_LIMIT = 2000;

    // Register write order; position i carries index i
    localparam logic [CFG_IDX_W-1:0] REG_ORDER [8] = '{
        CFG_RESET_LOW, CFG_RESET_REL, CFG_ONE_LOW, CFG_ONE_SLOT,
        CFG_ZERO_LOW, CFG_ZERO_SLOT, CFG_READ_SAMPLE, CFG_READ_SLOT
    };

    typedef logic [CFG_DATA_W-1:0] timing_set_t [8];

    typedef enum int {
        TIM_SMALL,      // short random spans, zeros and overlaps included
        TIM_ZERO,       // every span zero, which the block treats as one tick
        TIM_MIN,        // the lowest values that the bus timing allows
        TIM_MAX,        // every register at full scale, reset pulse included
        TIM_MAX_SLOTS   // zero-length reset, full-scale bit slots
    } timing_kind_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int   mismatches;
    int   pending;
    int   readings;
    logic sequence_running;

    bit   steady_source;
    bit   steady_sink;
    int   ready_left;
    int   idle_cycles;

    owtr_in_if  tick_if ();
    owtr_out_if res_if ();

    onewire_temperature_reader u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_in   (tick_if),
        .res_out   (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    owtr_reading_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .tick_valid       (tick_if.valid),
        .tick_ready       (tick_if.ready),
        .cmd              (tick_if.cmd),
        .bus_level        (tick_if.bus_level),
        .res_valid        (res_if.valid),
        .res_ready        (res_if.ready),
        .drive_low        (res_if.drive_low),
        .busy_res         (res_if.busy_res),
        .done_res         (res_if.done_res),
        .raw_reading      (res_if.raw_reading),
        .whole_degrees    (res_if.whole_degrees),
        .hundredths       (res_if.hundredths),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .pending          (pending),
        .readings         (readings),
        .sequence_running (sequence_running)
    );

    initial
        clk = 1'b0;

    always #6 clk = ~clk;

    // Result sink: mostly ready in bursts, short stalls now and then, and the
    // odd long one so that back-pressure lands on every step of the sequence.
    always @(negedge clk)
    begin
        int roll;
        if (ready_left > 0)
            ready_left--;
        else if (steady_sink)
            res_if.ready <= 1'b1;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                res_if.ready <= 1'b1;
                ready_left = $urandom_range(0, 7);
            end
            else if (roll < 96)
            begin
                res_if.ready <= 1'b0;
                ready_left = $urandom_range(0, 2);
            end
            else
            begin
                res_if.ready <= 1'b0;
                ready_left = $urandom_range(14, 39);
            end
        end
    end

    // Watchdog: any transaction on either channel clears the count
    always @(posedge clk)
    begin
        if (!rst_n || (tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL onewire_temperature_reader");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Sender gap before a tick: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        if (steady_source)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic timing_set_t choose_timings(input timing_kind_t kind);
        timing_set_t t;
        case (kind)
            TIM_ZERO:
                foreach (t[i])
                    t[i] = '0;
            TIM_MIN:
                t = '{10'd1, 10'd1, 10'd1, 10'd2, 10'd1, 10'd2, 10'd3, 10'd4};
            TIM_MAX:
                foreach (t[i])
                    t[i] = '1;
            TIM_MAX_SLOTS:
            begin
                // upper bits set on the byte-wide registers must be masked off
                foreach (t[i])
                    t[i] = '1;
                t[0] = '0;
                t[1] = '0;
            end
            default:
            begin
                t[0] = CFG_DATA_W'($urandom_range(0, 4));
                t[1] = CFG_DATA_W'($urandom_range(0, 4));
                for (int i = 2; i < 8; i++)
                    t[i] = CFG_DATA_W'($urandom_range(0, 6));
                // sample point may sit in the low part or beyond the slot end
                t[6] = CFG_DATA_W'($urandom_range(0, 9));
                if ($urandom_range(0, 3) == 0)
                    for (int i = 2; i < 8; i++)
                        t[i][CFG_DATA_W-1:BYTE_W] = 2'($urandom_range(0, 3));
            end
        endcase
        return t;
    endfunction

    // Offer one tick and hold it until the block takes it. Entered and left at a
    // falling edge; valid is left high so a back-to-back tick needs no toggle.
    task automatic send_tick(input logic start, input logic level);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            tick_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick_if.valid     <= 1'b1;
        tick_if.cmd       <= start;
        tick_if.bus_level <= level;
        @(posedge clk);
        while (!tick_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and hold off until every reading owed has been collected
    task automatic hold_until_drained();
        tick_if.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Write all eight timing registers on consecutive edges, then drop the enable
    task automatic load_timings(input timing_set_t t);
        for (int i = 0; i < 8; i++)
        begin
            if (i > 0)
                @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_data  <= t[i];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Run a measurement, or carry on with one under way, until it ends or the budget is spent.
    // The sensor may stay silent for a while so the conversion poll reads
    // all-zero bytes and repeats; after that the line carries random bits,
    // which become the temperature bytes. Starts while busy are sprinkled in.
    task automatic run_measurement(input int budget, inout int ticks_sent);
        int sent;
        int silent;
        sent   = 0;
        silent = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120) : 0;
        if (!sequence_running)
        begin
            repeat ($urandom_range(0, 3))
            begin
                send_tick(1'b0, 1'($urandom_range(0, 1)));
                sent++;
            end
            send_tick(1'b1, 1'($urandom_range(0, 1)));
            sent++;
        end
        while (sequence_running && sent < budget)
        begin
            send_tick(1'($urandom_range(0, 9) == 0),
                      (sent < silent) ? 1'b0 : 1'($urandom_range(0, 1)));
            sent++;
        end
        ticks_sent += sent;
    endtask

    initial
    begin
        int           random_ticks;
        int           phase_no;
        timing_kind_t kind;

        // Every input known from time zero; reset is held, then released at a falling edge
        rst_n             = 1'b0;
        tick_if.valid     = 1'b0;
        tick_if.cmd       = 1'b0;
        tick_if.bus_level = 1'b0;
        res_if.ready      = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_RESET_LOW;
        cfg_data          = '0;
        steady_source     = 1'b0;
        steady_sink       = 1'b0;
        ready_left        = 0;
        idle_cycles       = 0;
        random_ticks      = 0;
        phase_no          = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: plain ticks on both line levels while idle, then a start that
        // must drive low on its own tick, then starts that must be ignored while busy.
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);

        // Random phases. The sequence begun above is still in its default-length
        // reset pulse, so the first write lands mid-sequence and takes effect at
        // once. The full-scale phases run only part of a sequence under a short
        // budget; the phase after them shortens the timings and finishes it.
        while (random_ticks < 1350 || readings < 3)
        begin
            hold_until_drained();
            case (phase_no)
                0:       kind = TIM_ZERO;
                1:       kind = TIM_MIN;
                2:       kind = TIM_MAX;
                3:       kind = TIM_MAX_SLOTS;
                default: kind = ($urandom_range(0, 7) == 0) ? TIM_MIN : TIM_SMALL;
            endcase
            load_timings(choose_timings(kind));
            steady_source = ($urandom_range(0, 3) == 0);
            steady_sink   = ($urandom_range(0, 3) == 0);
            case (kind)
                TIM_MAX:       run_measurement(400, random_ticks);
                TIM_MAX_SLOTS: run_measurement(300, random_ticks);
                default:       run_measurement(3000, random_ticks);
            endcase
            phase_no++;
        end

        // Collect what is owed, then let anything stray arrive before the verdict
        hold_until_drained();
        repeat (4) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS onewire_temperature_reader");
        else
            $display("FAIL onewire_temperature_reader");
        $finish;
    end

endmodule

// ----- onewire_temperature_reader.f -----
+incdir+sv
sv/owtr_pkg.sv
sv/owtr_if.sv
sv/owtr_core.sv
sv/onewire_temperature_reader.sv
sim/owtr_reading_checker.sv
sim/tb_top.sv
